>>> hdl/stereo_frame_energy_top_macros.svh
`ifndef STEREO_FRAME_ENERGY_TOP_MACROS_SVH
`define STEREO_FRAME_ENERGY_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SFE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define SFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Condition that must hold in the cycle after reset was sampled high.
`define SFE_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("post-reset check failed");

`endif

>>> hdl/sfe_pkg.sv
package sfe_pkg;

   localparam int SUM_W   = 48;
   localparam int CNT_W   = 32;
   localparam int CFG_W   = 11;
   localparam int SQ_W    = 31;
   localparam int SMP_W   = 16;
   localparam int EN_W    = 31;
   localparam int FN_W    = 16;
   localparam int DIV_DW  = 48;
   localparam int CSR_IDX_W = 1;

   localparam int MAX_WINDOW_DEF = 1024;
   localparam int MAX_PENDING    = 63;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CFG_W-1:0] HOP_RESET = 11'd512;
   localparam logic [CFG_W-1:0] WIN_RESET = 11'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_HOP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN = 1'b1;

   // One accepted item as handed from the front part to the back part.
   typedef struct packed {
      logic [SUM_W-1:0] prev_sum_one;
      logic [SUM_W-1:0] prev_sum_two;
      logic [SUM_W-1:0] sum_one;
      logic [SUM_W-1:0] sum_two;
      logic [CNT_W-1:0] prev;
      logic             eos;
      logic [CFG_W-1:0] hop;
      logic [CFG_W-1:0] win;
   } job_type;

endpackage

>>> hdl/stereo_frame_energy_top.sv
// Framed mean-square energy of a stereo Q1.15 stream. Each item is one sample pair; a full
// frame result (unsigned Q1.30 per channel) leaves when window_length samples of a frame
// have arrived; the end-of-stream item flushes the frames still open, at most the newest 63,
// as partial frames. The front stage takes one item a cycle into a two-entry queue while there
// is room. The back sequencer takes one item at a time, using two 48-step restoring dividers
// that run side by side to find the frame position. Each result then needs the two mean
// divisions, and the next, read and load states sit between consecutive results of the same
// item. Stalls on the result channel hold the sequencer, so an end of stream with many open
// frames takes correspondingly longer. The history memory needs no clearing pass after reset.
module stereo_frame_energy_top #(
   parameter int MAX_WINDOW = sfe_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [sfe_pkg::SMP_W-1:0] req_sample_one,
   input  logic signed [sfe_pkg::SMP_W-1:0] req_sample_two,
   input  logic                             req_end_of_stream,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sfe_pkg::EN_W-1:0]         rsp_energy_one,
   output logic [sfe_pkg::EN_W-1:0]         rsp_energy_two,
   output logic [sfe_pkg::FN_W-1:0]         rsp_frame_number,
   output logic                             rsp_partial_frame,
   output logic                             rsp_last_of_run,
   input  logic                             csr_write_enable,
   input  logic [sfe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfe_pkg::CFG_W-1:0]        csr_data
);
   import sfe_pkg::*;

   localparam int POS_W = $clog2(MAX_WINDOW);
   localparam int QW    = $bits(job_type) + POS_W;

   job_type            job_f, job_b;
   logic [POS_W-1:0]   pos_f, pos_b;
   logic               q_push, q_pop, q_full, q_empty;
   logic [QW-1:0]      q_rdata;
   logic               ram_we;
   logic [POS_W-1:0]   ram_waddr, ram_raddr;
   logic [2*SUM_W-1:0] ram_wdata, ram_rdata;

   sfe_front #(.MAX_WINDOW(MAX_WINDOW), .POS_W(POS_W)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample_one(req_sample_one), .req_sample_two(req_sample_two),
      .req_end_of_stream(req_end_of_stream),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data),
      .q_full(q_full), .q_push(q_push), .job(job_f), .job_pos(pos_f)
   );

   sfe_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .wdata({job_f, pos_f}),
      .pop(q_pop), .rdata(q_rdata), .full(q_full), .empty(q_empty)
   );

   assign {job_b, pos_b} = q_rdata;

   sfe_ram #(.WIDTH(2 * SUM_W), .DEPTH(MAX_WINDOW)) u_history (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   sfe_back #(.MAX_WINDOW(MAX_WINDOW), .POS_W(POS_W)) u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_pop(q_pop), .job(job_b), .job_pos(pos_b),
      .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
      .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_energy_one(rsp_energy_one), .rsp_energy_two(rsp_energy_two),
      .rsp_frame_number(rsp_frame_number), .rsp_partial_frame(rsp_partial_frame),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

>>> hdl/sfe_ram.sv
module sfe_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/sfe_queue.sv
module sfe_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    count_ff;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= bump(wr_ff);
         end
         if (pop) begin
            rd_ff <= bump(rd_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= wdata;
      end
   end

endmodule

>>> hdl/sfe_div.sv
module sfe_div #(
   parameter int DW = 48,
   parameter int VW = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int CW = $clog2(DW);

   logic [DW-1:0] q_ff;
   logic [VW-1:0] r_ff, d_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [VW:0]   shifted;
   logic [VW+1:0] diff;

   // Restoring division, one quotient bit per cycle.
   assign shifted = {r_ff, q_ff[DW-1]};
   assign diff    = {1'b0, shifted} - {2'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         r_ff   <= '0;
         d_ff   <= divisor;
         cnt_ff <= CW'(DW - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (!diff[VW+1]) begin
            r_ff <= diff[VW-1:0];
            q_ff <= {q_ff[DW-2:0], 1'b1};
         end else begin
            r_ff <= shifted[VW-1:0];
            q_ff <= {q_ff[DW-2:0], 1'b0};
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

>>> hdl/sfe_front.sv
module sfe_front #(
   parameter int MAX_WINDOW = sfe_pkg::MAX_WINDOW_DEF,
   parameter int POS_W      = $clog2(sfe_pkg::MAX_WINDOW_DEF)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sfe_pkg::SMP_W-1:0]    req_sample_one,
   input  logic signed [sfe_pkg::SMP_W-1:0]    req_sample_two,
   input  logic                                req_end_of_stream,
   input  logic                                csr_write_enable,
   input  logic [sfe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sfe_pkg::CFG_W-1:0]           csr_data,
   input  logic                                q_full,
   output logic                                q_push,
   output sfe_pkg::job_type                    job,
   output logic [POS_W-1:0]                    job_pos
);
   import sfe_pkg::*;

   logic             st_valid_ff;
   logic [SQ_W-1:0]  sq_one_ff, sq_two_ff;
   logic             eos_ff;
   logic [CFG_W-1:0] hop_ff, win_ff;
   logic [SUM_W-1:0] sum_one_ff, sum_two_ff;
   logic [CNT_W-1:0] count_ff;
   logic [POS_W-1:0] pos_ff;
   logic             accept, push;
   logic signed [2*SMP_W-1:0] prod_one, prod_two;
   logic [CFG_W-1:0] eff_hop, eff_win;

   assign prod_one = req_sample_one * req_sample_one;
   assign prod_two = req_sample_two * req_sample_two;

   assign push      = st_valid_ff && !q_full;
   assign q_push    = push;
   assign req_stall = st_valid_ff && !push;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      eff_hop = (hop_ff == '0) ? CFG_W'(1) : hop_ff;
      if (win_ff == '0) begin
         eff_win = CFG_W'(1);
      end else if (int'(win_ff) > MAX_WINDOW) begin
         eff_win = CFG_W'(MAX_WINDOW);
      end else begin
         eff_win = win_ff;
      end
   end

   always_comb begin
      job.prev_sum_one = sum_one_ff;
      job.prev_sum_two = sum_two_ff;
      job.sum_one      = sum_one_ff + SUM_W'(sq_one_ff);
      job.sum_two      = sum_two_ff + SUM_W'(sq_two_ff);
      job.prev         = count_ff;
      job.eos          = eos_ff;
      job.hop          = eff_hop;
      job.win          = eff_win;
   end
   assign job_pos = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
         hop_ff      <= HOP_RESET;
         win_ff      <= WIN_RESET;
         sum_one_ff  <= '0;
         sum_two_ff  <= '0;
         count_ff    <= '0;
         pos_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_HOP: hop_ff <= csr_data;
               CSR_WIN: win_ff <= csr_data;
            endcase
         end
         if (accept) begin
            st_valid_ff <= 1'b1;
         end else if (push) begin
            st_valid_ff <= 1'b0;
         end
         if (push) begin
            if (eos_ff) begin
               sum_one_ff <= '0;
               sum_two_ff <= '0;
               count_ff   <= '0;
               pos_ff     <= '0;
            end else begin
               sum_one_ff <= job.sum_one;
               sum_two_ff <= job.sum_two;
               count_ff   <= count_ff + 1'b1;
               // The ring position follows the sample count, also across its wrap.
               if (count_ff == '1 || pos_ff == POS_W'(MAX_WINDOW - 1)) begin
                  pos_ff <= '0;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_one_ff <= prod_one[SQ_W-1:0];
         sq_two_ff <= prod_two[SQ_W-1:0];
         eos_ff    <= req_end_of_stream;
      end
   end

endmodule

>>> hdl/sfe_back.sv
module sfe_back #(
   parameter int MAX_WINDOW = sfe_pkg::MAX_WINDOW_DEF,
   parameter int POS_W      = $clog2(sfe_pkg::MAX_WINDOW_DEF)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  sfe_pkg::job_type              job,
   input  logic [POS_W-1:0]              job_pos,
   output logic                          ram_we,
   output logic [POS_W-1:0]              ram_waddr,
   output logic [2*sfe_pkg::SUM_W-1:0]   ram_wdata,
   output logic [POS_W-1:0]              ram_raddr,
   input  logic [2*sfe_pkg::SUM_W-1:0]   ram_rdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sfe_pkg::EN_W-1:0]      rsp_energy_one,
   output logic [sfe_pkg::EN_W-1:0]      rsp_energy_two,
   output logic [sfe_pkg::FN_W-1:0]      rsp_frame_number,
   output logic                          rsp_partial_frame,
   output logic                          rsp_last_of_run
);
   import sfe_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WRITE = 4'd1;
   localparam logic [3:0] ST_DIVH  = 4'd2;
   localparam logic [3:0] ST_PLAN  = 4'd3;
   localparam logic [3:0] ST_CAP   = 4'd4;
   localparam logic [3:0] ST_NEXT  = 4'd5;
   localparam logic [3:0] ST_READ  = 4'd6;
   localparam logic [3:0] ST_LOAD  = 4'd7;
   localparam logic [3:0] ST_DIVE  = 4'd8;
   localparam logic [3:0] ST_EMIT  = 4'd9;

   localparam int IW = POS_W + 13;
   localparam int SW = CNT_W + 2;

   logic [3:0]       state_ff, state_in;
   job_type          job_ff;
   logic [POS_W-1:0] pos_ff, idx_ff;
   logic [CNT_W:0]   n_ff, n_calc;
   logic [SW-1:0]    lo_ff, lo_calc, first_ff, fnp_ff, last_ff, qa_ff, qp_ff;
   logic [CFG_W-1:0] ra_ff, rp_ff, len_ff;
   logic             full_ff, more_part, emit_go;
   logic [FN_W-1:0]  fn_ff;
   logic             part_ff, last_flag_ff;
   logic             rsp_valid_ff;
   logic [EN_W-1:0]  en_one_ff, en_two_ff;
   logic [FN_W-1:0]  fn_out_ff;
   logic             part_out_ff, last_out_ff;

   logic              div_start, a_done;
   logic [DIV_DW-1:0] a_dividend, b_dividend, a_q, b_q;
   logic [CFG_W-1:0]  div_divisor, a_r, b_r;

   logic [SW-1:0]    sel_s, len_calc;
   logic [IW-1:0]    idx_t;
   logic [SW-1:0]    cap_first;

   sfe_div #(.DW(DIV_DW), .VW(CFG_W)) u_div_a (
      .clock(clock), .reset(reset), .start(div_start), .dividend(a_dividend),
      .divisor(div_divisor), .done(a_done), .quotient(a_q), .remainder(a_r)
   );

   sfe_div #(.DW(DIV_DW), .VW(CFG_W)) u_div_b (
      .clock(clock), .reset(reset), .start(div_start), .dividend(b_dividend),
      .divisor(div_divisor), .done(), .quotient(b_q), .remainder(b_r)
   );

   assign n_calc    = (CNT_W + 1)'(job_ff.prev) + 1'b1;
   assign lo_calc   = SW'(n_calc) - SW'(job_ff.win);
   assign more_part = job_ff.eos && (fnp_ff <= qp_ff);
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;

   assign ram_we    = (state_ff == ST_WRITE);
   assign ram_waddr = pos_ff;
   assign ram_wdata = {job_ff.prev_sum_two, job_ff.prev_sum_one};
   assign ram_raddr = idx_ff;

   // Frame start, its length, and its slot in the ring.
   always_comb begin
      sel_s    = full_ff ? lo_ff : first_ff;
      len_calc = SW'(n_ff) - sel_s;
      idx_t    = IW'(pos_ff) + IW'(1) - IW'(len_calc[CFG_W-1:0]);
      if (idx_t[IW-1]) begin
         idx_t = idx_t + IW'(MAX_WINDOW);
      end
      cap_first = last_ff - SW'(job_ff.hop) * SW'(MAX_PENDING - 1);
   end

   always_comb begin
      div_start   = 1'b0;
      a_dividend  = '0;
      b_dividend  = '0;
      div_divisor = job_ff.hop;
      unique case (state_ff)
         ST_WRITE: begin
            div_start  = 1'b1;
            a_dividend = lo_calc[SW-1] ? '0 : DIV_DW'(lo_calc[CNT_W:0]);
            b_dividend = DIV_DW'(job_ff.prev);
         end
         ST_LOAD: begin
            div_start   = 1'b1;
            a_dividend  = job_ff.sum_one - ram_rdata[SUM_W-1:0];
            b_dividend  = job_ff.sum_two - ram_rdata[2*SUM_W-1:SUM_W];
            div_divisor = len_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (!q_empty) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_DIVH;
         ST_DIVH:  if (a_done) state_in = ST_PLAN;
         ST_PLAN:  state_in = ST_CAP;
         ST_CAP:   state_in = ST_NEXT;
         ST_NEXT:  state_in = (full_ff || more_part) ? ST_READ : ST_IDLE;
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_DIVE;
         ST_DIVE:  if (a_done) state_in = ST_EMIT;
         ST_EMIT:  if (emit_go) state_in = last_flag_ff ? ST_IDLE : ST_NEXT;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_PLAN) begin
            full_ff <= !lo_ff[SW-1] && (ra_ff == '0);
         end else if (state_ff == ST_NEXT) begin
            full_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            job_ff <= job;
            pos_ff <= job_pos;
         end
         ST_WRITE: begin
            n_ff  <= n_calc;
            lo_ff <= lo_calc;
         end
         ST_DIVH: begin
            qa_ff <= a_q[SW-1:0];
            ra_ff <= a_r;
            qp_ff <= b_q[SW-1:0];
            rp_ff <= b_r;
         end
         ST_PLAN: begin
            last_ff <= SW'(job_ff.prev) - SW'(rp_ff);
            if (lo_ff[SW-1]) begin
               first_ff <= '0;
               fnp_ff   <= '0;
            end else begin
               first_ff <= lo_ff - SW'(ra_ff) + SW'(job_ff.hop);
               fnp_ff   <= qa_ff + 1'b1;
            end
         end
         ST_CAP: begin
            // Only the newest frames survive when too many are pending.
            if (fnp_ff <= qp_ff &&
                (SW + 1)'(qp_ff) >= (SW + 1)'(fnp_ff) + (SW + 1)'(MAX_PENDING)) begin
               fnp_ff   <= qp_ff - SW'(MAX_PENDING - 1);
               first_ff <= cap_first;
            end
         end
         ST_NEXT: begin
            len_ff <= len_calc[CFG_W-1:0];
            idx_ff <= idx_t[POS_W-1:0];
            if (full_ff) begin
               fn_ff        <= qa_ff[FN_W-1:0];
               part_ff      <= 1'b0;
               last_flag_ff <= !more_part;
            end else begin
               fn_ff        <= fnp_ff[FN_W-1:0];
               part_ff      <= 1'b1;
               last_flag_ff <= (fnp_ff == qp_ff);
               first_ff     <= first_ff + SW'(job_ff.hop);
               fnp_ff       <= fnp_ff + 1'b1;
            end
         end
         default: ;
      endcase
      if (emit_go) begin
         en_one_ff   <= a_q[EN_W-1:0];
         en_two_ff   <= b_q[EN_W-1:0];
         fn_out_ff   <= fn_ff;
         part_out_ff <= part_ff;
         last_out_ff <= last_flag_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_energy_one    = en_one_ff;
   assign rsp_energy_two    = en_two_ff;
   assign rsp_frame_number  = fn_out_ff;
   assign rsp_partial_frame = part_out_ff;
   assign rsp_last_of_run   = last_out_ff;

endmodule

>>> hdl/sfe_checker.sv
`include "stereo_frame_energy_top_macros.svh"

module sfe_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [sfe_pkg::EN_W-1:0]      rsp_energy_one,
   input logic [sfe_pkg::EN_W-1:0]      rsp_energy_two,
   input logic [sfe_pkg::FN_W-1:0]      rsp_frame_number
);

   // A mean of squares of Q1.15 values never exceeds one in Q1.30.
   `SFE_ASSERT_IMPLY(a_energy_one_max, clock, reset, rsp_valid, rsp_energy_one <= 31'h4000_0000)
   `SFE_ASSERT_IMPLY(a_energy_two_max, clock, reset, rsp_valid, rsp_energy_two <= 31'h4000_0000)

   `SFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frame_number) && $stable(rsp_energy_one))

   // Nothing is in flight once reset has been applied.
   `SFE_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid && !req_stall)

endmodule

bind stereo_frame_energy_top sfe_checker u_sfe_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_energy_one(rsp_energy_one),
   .rsp_energy_two(rsp_energy_two),
   .rsp_frame_number(rsp_frame_number)
);

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sfe_pkg::*;

   localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
   localparam longint unsigned MASK31 = 64'h7FFF_FFFF;
   localparam int HIST_DEPTH = 1024;
   localparam int PEND_LIMIT = 63;
   localparam int SETTLE_CYCLES = 300;
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct {
      logic signed [SMP_W-1:0] one;
      logic signed [SMP_W-1:0] two;
      logic                    eos;
   } sample_pair_t;

   typedef struct {
      logic [EN_W-1:0] energy_one;
      logic [EN_W-1:0] energy_two;
      logic [FN_W-1:0] frame_number;
      logic            partial;
      logic            last;
   } frame_energy_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SMP_W-1:0] req_sample_one = '0;
   logic signed [SMP_W-1:0] req_sample_two = '0;
   logic req_end_of_stream = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [EN_W-1:0] rsp_energy_one;
   logic [EN_W-1:0] rsp_energy_two;
   logic [FN_W-1:0] rsp_frame_number;
   logic rsp_partial_frame;
   logic rsp_last_of_run;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HOP;
   logic [CFG_W-1:0] csr_data = '0;

   stereo_frame_energy_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample_one(req_sample_one), .req_sample_two(req_sample_two),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_energy_one(rsp_energy_one), .rsp_energy_two(rsp_energy_two),
      .rsp_frame_number(rsp_frame_number), .rsp_partial_frame(rsp_partial_frame),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   sample_pair_t  sample_q[$];
   frame_energy_t energy_q[$];

   // Shadow of the block's state.
   logic [SUM_W-1:0] prefix_hist_one[HIST_DEPTH];
   logic [SUM_W-1:0] prefix_hist_two[HIST_DEPTH];
   logic [SUM_W-1:0] prefix_one = '0;
   logic [SUM_W-1:0] prefix_two = '0;
   logic [CNT_W-1:0] count_in_stream = '0;
   logic [CFG_W-1:0] hop_cfg = HOP_RESET;
   logic [CFG_W-1:0] win_cfg = WIN_RESET;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_left = 0;
   bit  hold_request = 0;
   bit  item_taken = 0;
   int  errors = 0;
   longint cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned square_of(logic signed [SMP_W-1:0] v);
      longint sv;
      sv = v;
      return longint'(sv * sv);
   endfunction

   function automatic void push_frame(longint s, longint n, longint unsigned hop_e,
                                      bit partial);
      frame_energy_t f;
      longint unsigned idx, len, d1, d2;
      idx = longint'(s) % HIST_DEPTH;
      len = n - s;
      d1 = (longint'(prefix_one) - longint'(prefix_hist_one[idx])) & MASK48;
      d2 = (longint'(prefix_two) - longint'(prefix_hist_two[idx])) & MASK48;
      f.energy_one = EN_W'((d1 / len) & MASK31);
      f.energy_two = EN_W'((d2 / len) & MASK31);
      f.frame_number = FN_W'((longint'(s) / hop_e) & 16'hFFFF);
      f.partial = partial;
      f.last = 1'b0;
      energy_q.push_back(f);
   endfunction

   // Works out every frame energy that one accepted sample pair produces.
   function automatic void predict_energy(sample_pair_t it);
      longint unsigned hop_e, win_e;
      longint n, prev, lo, last_start, first_start, cnt, s;
      int start_size;
      start_size = energy_q.size();
      hop_e = (hop_cfg == 0) ? 1 : hop_cfg;
      win_e = (win_cfg == 0) ? 1 : ((win_cfg > HIST_DEPTH) ? HIST_DEPTH : win_cfg);
      prev = count_in_stream;
      n = prev + 1;
      prefix_hist_one[prev % HIST_DEPTH] = prefix_one;
      prefix_hist_two[prev % HIST_DEPTH] = prefix_two;
      prefix_one = SUM_W'((prefix_one + square_of(it.one)) & MASK48);
      prefix_two = SUM_W'((prefix_two + square_of(it.two)) & MASK48);
      if (n >= longint'(win_e) && ((n - longint'(win_e)) % longint'(hop_e)) == 0)
         push_frame(n - longint'(win_e), n, hop_e, 1'b0);
      if (it.eos) begin
         lo = n - longint'(win_e);
         last_start = ((n - 1) / longint'(hop_e)) * longint'(hop_e);
         if (lo < 0) first_start = 0;
         else first_start = (lo / longint'(hop_e) + 1) * longint'(hop_e);
         if (first_start <= last_start) begin
            cnt = (last_start - first_start) / longint'(hop_e) + 1;
            if (cnt > PEND_LIMIT)
               first_start = last_start - longint'(PEND_LIMIT - 1) * longint'(hop_e);
            for (s = first_start; s <= last_start; s += longint'(hop_e))
               push_frame(s, n, hop_e, 1'b1);
         end
      end
      if (energy_q.size() > start_size) energy_q[$].last = 1'b1;
      if (it.eos) begin
         prefix_one = '0;
         prefix_two = '0;
         count_in_stream = '0;
      end else begin
         count_in_stream = count_in_stream + 1'b1;
      end
   endfunction

   // Accepted items and results, sampled at the rising edge.
   always @(posedge clock) begin
      frame_energy_t f;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL stereo_frame_energy_top");
         $finish;
      end else if (!reset) begin
         item_taken = req_valid && !req_stall;
         if (item_taken)
            predict_energy('{one: req_sample_one, two: req_sample_two,
                             eos: req_end_of_stream});
         if (rsp_valid && !rsp_stall) begin
            if (energy_q.size() == 0) begin
               $error("result with no expected frame energy waiting");
               errors++;
            end else begin
               f = energy_q.pop_front();
               if (rsp_energy_one !== f.energy_one) begin
                  $error("energy_one: expected %0d actual %0d", f.energy_one, rsp_energy_one);
                  errors++;
               end
               if (rsp_energy_two !== f.energy_two) begin
                  $error("energy_two: expected %0d actual %0d", f.energy_two, rsp_energy_two);
                  errors++;
               end
               if (rsp_frame_number !== f.frame_number) begin
                  $error("frame_number: expected %0d actual %0d", f.frame_number,
                         rsp_frame_number);
                  errors++;
               end
               if (rsp_partial_frame !== f.partial) begin
                  $error("partial_frame: expected %0d actual %0d", f.partial,
                         rsp_partial_frame);
                  errors++;
               end
               if (rsp_last_of_run !== f.last) begin
                  $error("last_of_run: expected %0d actual %0d", f.last, rsp_last_of_run);
                  errors++;
               end
            end
         end
      end
   end

   // Sample driver: a new item goes out only once the previous one was taken.
   always @(negedge clock) begin
      sample_pair_t it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || item_taken) begin
         if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = sample_q.pop_front();
            req_valid <= 1'b1;
            req_sample_one <= it.one;
            req_sample_two <= it.two;
            req_end_of_stream <= it.eos;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver, with an optional long hold-off.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = 3000;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      if (idx == CSR_HOP) hop_cfg = value;
      else win_cfg = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_frames(logic [CFG_W-1:0] hop, logic [CFG_W-1:0] win);
      write_csr(CSR_HOP, hop);
      write_csr(CSR_WIN, win);
   endtask

   task automatic wait_idle();
      while (sample_q.size() > 0 || req_valid || energy_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SMP_W-1:0] rand_sample();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return SMP_W'($urandom);
      endcase
   endfunction

   task automatic add_stream(int len, bit end_it);
      sample_pair_t it;
      for (int i = 0; i < len; i++) begin
         it.one = rand_sample();
         it.two = rand_sample();
         it.eos = end_it && (i == len - 1);
         sample_q.push_back(it);
      end
   endtask

   // Random items; each one ends its stream with a chance of one in twelve.
   task automatic add_random(int count);
      sample_pair_t it;
      for (int i = 0; i < count; i++) begin
         it.one = rand_sample();
         it.two = rand_sample();
         it.eos = ($urandom_range(11) == 0);
         sample_q.push_back(it);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with reset frame settings: short streams flushed early.
      sample_q.push_back('{one: 16'sh8000, two: 16'sh7FFF, eos: 1'b1});
      sample_q.push_back('{one: 16'sh7FFF, two: 16'sh8000, eos: 1'b0});
      sample_q.push_back('{one: 16'sh0000, two: 16'shFFFF, eos: 1'b0});
      sample_q.push_back('{one: 16'sh0001, two: 16'sh8000, eos: 1'b1});
      wait_idle();

      // Zero hop and zero window both act as one: every item closes a frame.
      set_frames(11'd0, 11'd0);
      add_stream(4, 1);
      wait_idle();

      // Window much longer than 63 hops: only the newest open frames flush.
      set_frames(11'd1, 11'd70);
      add_stream(75, 1);
      wait_idle();

      // Settings above range, then the largest in-range ones.
      set_frames(11'd2047, 11'd2047);
      add_stream(3, 1);
      wait_idle();
      set_frames(11'd1024, 11'd1024);
      add_stream(3, 1);
      wait_idle();

      // Frame that fills exactly on the end item, followed by partial frames.
      set_frames(11'd2, 11'd4);
      add_stream(6, 1);
      wait_idle();

      send_idle_pct = 31;
      recv_idle_pct = 67;
      set_frames(11'd3, 11'd8);
      add_random(20);
      wait_idle();

      send_idle_pct = 67;
      recv_idle_pct = 31;
      set_frames(11'd1, 11'd5);
      add_random(20);
      wait_idle();

      // No idling, and a long receiver hold-off so the block backs up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_frames(11'd2, 11'd6);
      hold_request = 1;
      add_random(20);
      wait_idle();

      if (errors == 0) begin
         $display("PASS stereo_frame_energy_top");
      end else begin
         $display("FAIL stereo_frame_energy_top");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sfe_pkg.sv
hdl/sfe_ram.sv
hdl/sfe_queue.sv
hdl/sfe_div.sv
hdl/sfe_front.sv
hdl/sfe_back.sv
hdl/stereo_frame_energy_top.sv
hdl/sfe_checker.sv
test/testbench.sv
